// ===== hdl/bsv_pkg.sv =====
// Shared types, character codes and helper functions of the bencode stream validator.
`timescale 1ns / 1ps

package bsv_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int unsigned MAX_NESTING_DEF = 32;
  localparam int unsigned LENGTH_BITS_DEF = 32;

  // Width of one stack entry.
  localparam int unsigned KIND_W = 2;

  // Characters that steer the parser.
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_L     = 8'h6C;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [3:0] {
    MODE_EXPECT   = 4'd0,
    MODE_INT_SIGN = 4'd1,
    MODE_INT_DIG1 = 4'd2,
    MODE_INT_MORE = 4'd3,
    MODE_STR_LEN  = 4'd4,
    MODE_STR_BODY = 4'd5,
    MODE_DONE     = 4'd6
  } parse_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LIST     = 2'd0,
    KIND_DICT_KEY = 2'd2,
    KIND_DICT_VAL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SYNTAX = 3'd1,
    ERR_TRUNC  = 3'd2,
    ERR_TRAIL  = 3'd3,
    ERR_DEEP   = 3'd4,
    ERR_LENOVF = 3'd5
  } err_e;

  // Request from the parser to the level stack.
  typedef struct packed {
    logic  clear;
    logic  push;
    kind_e kind;
    logic  pop;
    logic  toggle;
  } stack_cmd_t;

  // Status of the level stack as seen by the parser.
  typedef struct packed {
    logic  empty;
    logic  single;
    logic  full;
    kind_e top;
  } stack_sts_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // A finished value moves a dictionary between key and value position.
  function automatic kind_e advance_kind(input kind_e k);
    kind_e r;
    r = k;
    if (k == KIND_DICT_KEY) begin
      r = KIND_DICT_VAL;
    end else if (k == KIND_DICT_VAL) begin
      r = KIND_DICT_KEY;
    end
    return r;
  endfunction

endpackage

// ===== hdl/bsv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bsv_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bsv_stack.sv =====
// Level stack: cached top entry in flops, lower entries in RAM with a prefetched read.
`timescale 1ns / 1ps

module bsv_stack import bsv_pkg::*; #(
  parameter int unsigned MAX_NESTING = MAX_NESTING_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stack_cmd_t cmd_i,
  output stack_sts_t sts_o
);

  localparam int unsigned DW = $clog2(MAX_NESTING + 1);
  localparam int unsigned AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic [DW-1:0]     depth_q, depth_d;
  kind_e             top_q, top_d;
  logic              fwd_q;
  kind_e             fwd_data_q;
  logic              we;
  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     rd_sel;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [KIND_W-1:0] rdata;
  kind_e             below;

  // The RAM always holds the entry just under the top at its read port; a push
  // that writes that very entry in the same cycle is forwarded.
  assign below = fwd_q ? fwd_data_q : kind_e'(rdata);

  always_comb begin
    depth_d = depth_q;
    top_d   = top_q;
    we      = 1'b0;
    if (cmd_i.clear) begin
      depth_d = '0;
    end else if (cmd_i.push) begin
      we      = (depth_q != '0);
      depth_d = depth_q + DW'(1);
      top_d   = cmd_i.kind;
    end else if (cmd_i.pop) begin
      depth_d = depth_q - DW'(1);
      top_d   = cmd_i.toggle ? advance_kind(below) : below;
    end else if (cmd_i.toggle && (depth_q != '0)) begin
      top_d = advance_kind(top_q);
    end
  end

  assign depth_m1 = depth_q - DW'(1);
  assign rd_sel   = depth_d - DW'(2);
  assign waddr    = depth_m1[AW-1:0];
  assign raddr    = rd_sel[AW-1:0];

  bsv_ram #(
    .WIDTH (KIND_W),
    .DEPTH (MAX_NESTING)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (top_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      top_q   <= KIND_LIST;
      fwd_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      top_q   <= top_d;
      fwd_q   <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= top_q;
  end

  assign sts_o.empty  = (depth_q == '0);
  assign sts_o.single = (depth_q == DW'(1));
  assign sts_o.full   = (depth_q == DW'(MAX_NESTING));
  assign sts_o.top    = top_q;

endmodule

// ===== hdl/bsv_parser.sv =====
// Byte parser: mode state machine, string length counter and first-error capture.
`timescale 1ns / 1ps

module bsv_parser import bsv_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  stack_sts_t sts_i,
  output stack_cmd_t cmd_o,
  output err_e       res_err_o
);

  localparam int unsigned LW = LENGTH_BITS + 4;

  parse_mode_e            mode_q, mode_d, mode_n;
  logic [LENGTH_BITS-1:0] rem_q, rem_d, rem_n;
  err_e                   err_q, err_d, err_n;

  logic          work;
  logic          dig_ok;
  logic [3:0]    dig;
  logic [LW-1:0] len_ext;
  logic          len_ovf;
  logic          want_key;
  logic          rem_zero;
  logic          rem_one;
  logic          is_open;

  assign work     = take_i && (err_q == ERR_NONE);
  assign dig_ok   = is_digit(data_byte_i);
  assign dig      = 4'(data_byte_i - CHAR_ZERO);
  // length * 10 + digit, built from shifts; any carry into the top nibble overflows.
  assign len_ext  = (LW'(rem_q) << 3) + (LW'(rem_q) << 1) + LW'(dig);
  assign len_ovf  = |len_ext[LW-1:LENGTH_BITS];
  assign want_key = !sts_i.empty && (sts_i.top == KIND_DICT_KEY);
  assign rem_zero = (rem_q == '0);
  assign rem_one  = (rem_q == LENGTH_BITS'(1));
  assign is_open  = (data_byte_i == CHAR_L) || (data_byte_i == CHAR_D);

  // Next state.
  always_comb begin
    mode_n = mode_q;
    rem_n  = rem_q;
    err_n  = err_q;
    if (work) begin
      unique case (mode_q)
        MODE_EXPECT: begin
          if (!sts_i.empty && (data_byte_i == CHAR_E)) begin
            if (sts_i.top == KIND_DICT_VAL) begin
              err_n = ERR_SYNTAX;
            end else begin
              mode_n = sts_i.single ? MODE_DONE : MODE_EXPECT;
            end
          end else if (dig_ok) begin
            rem_n  = LENGTH_BITS'(dig);
            mode_n = MODE_STR_LEN;
          end else if (want_key) begin
            err_n = ERR_SYNTAX;
          end else if (data_byte_i == CHAR_I) begin
            mode_n = MODE_INT_SIGN;
          end else if (is_open) begin
            if (sts_i.full) begin
              err_n = ERR_DEEP;
            end else begin
              mode_n = MODE_EXPECT;
            end
          end else begin
            err_n = ERR_SYNTAX;
          end
        end
        MODE_INT_SIGN: begin
          if (data_byte_i == CHAR_MINUS) begin
            mode_n = MODE_INT_DIG1;
          end else if (dig_ok) begin
            mode_n = MODE_INT_MORE;
          end else begin
            err_n = ERR_SYNTAX;
          end
        end
        MODE_INT_DIG1: begin
          if (dig_ok) begin
            mode_n = MODE_INT_MORE;
          end else begin
            err_n = ERR_SYNTAX;
          end
        end
        MODE_INT_MORE: begin
          if (data_byte_i == CHAR_E) begin
            mode_n = sts_i.empty ? MODE_DONE : MODE_EXPECT;
          end else if (!dig_ok) begin
            err_n = ERR_SYNTAX;
          end
        end
        MODE_STR_LEN: begin
          if (dig_ok) begin
            if (len_ovf) begin
              err_n = ERR_LENOVF;
            end else begin
              rem_n = len_ext[LENGTH_BITS-1:0];
            end
          end else if (data_byte_i == CHAR_COLON) begin
            if (rem_zero) begin
              mode_n = sts_i.empty ? MODE_DONE : MODE_EXPECT;
            end else begin
              mode_n = MODE_STR_BODY;
            end
          end else begin
            err_n = ERR_SYNTAX;
          end
        end
        MODE_STR_BODY: begin
          rem_n = rem_q - LENGTH_BITS'(1);
          if (rem_one) begin
            mode_n = sts_i.empty ? MODE_DONE : MODE_EXPECT;
          end
        end
        MODE_DONE: begin
          err_n = ERR_TRAIL;
        end
        default: begin
          err_n = ERR_SYNTAX;
        end
      endcase
    end

    if (take_i && last_byte_i) begin
      mode_d = MODE_EXPECT;
      rem_d  = '0;
      err_d  = ERR_NONE;
    end else begin
      mode_d = mode_n;
      rem_d  = rem_n;
      err_d  = err_n;
    end
  end

  assign res_err_o = ((err_n == ERR_NONE) && (mode_n != MODE_DONE)) ? ERR_TRUNC : err_n;

  // Stack requests.
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = KIND_LIST;
    if (take_i && last_byte_i) begin
      cmd_o.clear = 1'b1;
    end else if (work) begin
      unique case (mode_q)
        MODE_EXPECT: begin
          if (!sts_i.empty && (data_byte_i == CHAR_E)) begin
            if (sts_i.top != KIND_DICT_VAL) begin
              cmd_o.pop    = 1'b1;
              cmd_o.toggle = 1'b1;
            end
          end else if (!dig_ok && !want_key && is_open && !sts_i.full) begin
            cmd_o.push = 1'b1;
            cmd_o.kind = (data_byte_i == CHAR_D) ? KIND_DICT_KEY : KIND_LIST;
          end
        end
        MODE_INT_MORE: begin
          cmd_o.toggle = (data_byte_i == CHAR_E);
        end
        MODE_STR_LEN: begin
          cmd_o.toggle = (data_byte_i == CHAR_COLON) && rem_zero;
        end
        MODE_STR_BODY: begin
          cmd_o.toggle = rem_one;
        end
        default: begin
          cmd_o.toggle = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EXPECT;
      rem_q  <= '0;
      err_q  <= ERR_NONE;
    end else begin
      mode_q <= mode_d;
      rem_q  <= rem_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== hdl/bencode_stream_validator.sv =====
// Top level of the bencode stream validator: handshakes, parser, level stack and result register.
// Throughput: one byte per cycle while input is not held off; final bytes are taken like any other.
// The result of a buffer is registered and appears in the cycle after the transfer of its final byte.
// Input is held off only while a result sits in the output register and is not taken.
// Reset (rst_ni low, asynchronous) returns to the start of a buffer with an empty stack;
// the stack RAM needs no clearing pass, as every entry is written before it is read.
`timescale 1ns / 1ps

module bencode_stream_validator import bsv_pkg::*; #(
  parameter int unsigned MAX_NESTING = MAX_NESTING_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [2:0] error_kind_o
);

  logic       take;
  logic       load;
  logic       out_valid_q, out_valid_d;
  err_e       res_err;
  err_e       err_out_q;
  stack_cmd_t cmd;
  stack_sts_t sts;

  // The result register separates the two sides: a new byte is taken whenever the
  // register is empty or its content is being transferred in this same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign load       = take && last_byte_i;

  // The parser decides on the byte in the cycle of its transfer and tells the stack
  // whether to push, pop, clear or move a dictionary between key and value position.
  bsv_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .res_err_o   (res_err)
  );

  // The stack keeps its top entry in flops so the parser sees it at once; the
  // entries below live in RAM, and the one under the top is always prefetched so
  // that a pop on one byte and another decision on the next need no wait.
  bsv_stack #(
    .MAX_NESTING (MAX_NESTING)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_out_q <= res_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = (err_out_q == ERR_NONE);
  assign error_kind_o = err_out_q;

endmodule

// ===== hdl/bsv_checker.sv =====
// Port-level assertions for the bencode stream validator, bound to the top level.
`timescale 1ns / 1ps

module bsv_checker import bsv_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       valid_res_o,
  input logic [2:0] error_kind_o
);

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(error_kind_o) && $stable(valid_res_o))
    else $error("result changed while stalled");

  // The valid flag and the error code agree.
  a_res_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o == (error_kind_o == ERR_NONE)))
    else $error("valid_res_o disagrees with error_kind_o");

  // Input is held off only behind a result that waits.
  a_ready_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // The final byte of a buffer yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> out_valid_o)
    else $error("no result after final byte");

  // A result appears only after a final byte.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i))
    else $error("result without a final byte");

endmodule

bind bencode_stream_validator bsv_checker u_bsv_checker (.*);
